>>> sv/ipv6_text_parser_top_macros.svh
// Assertion macros for the IPv6 text parser.
// Uses the clk and rst_n names of the module that includes it.
`ifndef IPV6_TEXT_PARSER_TOP_MACROS_SVH
`define IPV6_TEXT_PARSER_TOP_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define IPV6TP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define IPV6TP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/ipv6tp_pkg.sv
// Package for the IPv6 text parser: beat types, parser phases, character codes
// and small character helpers. Depends on nothing.
package ipv6tp_pkg;

    // One character of address text.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    // One parse result.
    typedef struct packed {
        logic        valid_res;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } res_beat_t;

    // Where the parser stands within the text.
    typedef enum logic [2:0] {
        PH_START,
        PH_LEAD,
        PH_GAP,
        PH_SEP,
        PH_HEX,
        PH_IP4
    } phase_t;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [9:0] OCTET_MAX  = 10'd255;
    localparam int         GROUP_NUM  = 8;

    // True for a decimal digit.
    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // True for a hex digit of either case.
    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // Nibble value of a hex digit; letters have low bits 1..6 in ASCII.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (is_dec(c))
            v = c[3:0];
        else
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    // A finished token forms a legal dotted-quad octet.
    function automatic logic octet_good(input logic [2:0] dcnt,
                                        input logic       alldec,
                                        input logic [9:0] dacc,
                                        input logic       fzero);
        return (dcnt >= 3'd1) && (dcnt <= 3'd3) && alldec &&
               (dacc <= OCTET_MAX) && !(fzero && (dcnt > 3'd1));
    endfunction

endpackage

>>> sv/ipv6_text_parser_top.sv
// IPv6 address text parser: one character beat in, one result beat per text out.
// Depends on ipv6tp_pkg and ipv6_text_parser_top_macros.svh.
// Throughput: one character per cycle unless stalled; the state updates in one pass.
// Latency: the result beat is valid the cycle after the final character is taken.
// The result register decouples the sides: characters are taken while it is
// empty or being drained. Reset empties it and returns the parser to text start.
module ipv6_text_parser_top
    import ipv6tp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_beat_t char_beat,
    output logic       res_valid,
    input  logic       res_ready,
    output res_beat_t  res_beat
);

    // Parser state.
    phase_t       phase_reg, phase_next;
    logic         failed_reg, failed_next;
    logic [3:0]   gcnt_reg, gcnt_next;
    logic [3:0]   gpos_reg, gpos_next;
    logic         gseen_reg, gseen_next;
    logic [15:0]  hacc_reg, hacc_next;
    logic [9:0]   dacc_reg, dacc_next;
    logic [2:0]   dcnt_reg, dcnt_next;
    logic         alldec_reg, alldec_next;
    logic [1:0]   oidx_reg, oidx_next;
    logic         fzero_reg, fzero_next;
    // Groups and octets after the gap (or all of them without one), right aligned.
    logic [127:0] tail_reg, tail_next;
    // Groups before the gap, at their final slot.
    logic [15:0]  head_reg [GROUP_NUM];

    logic         res_valid_reg, res_valid_next;
    res_beat_t    res_beat_reg, res_beat_next;

    // Values after the character is taken.
    phase_t       t_phase;
    logic         t_failed;
    logic [3:0]   t_gcnt;
    logic [3:0]   t_gpos;
    logic         t_gseen;
    logic [15:0]  t_hacc;
    logic [9:0]   t_dacc;
    logic [2:0]   t_dcnt;
    logic         t_alldec;
    logic [1:0]   t_oidx;
    logic         t_fzero;
    logic [127:0] t_tail;
    logic         head_we;

    // Values after the end-of-text checks.
    logic         f_failed;
    logic [3:0]   f_gcnt;
    logic [127:0] f_tail;
    logic [127:0] addr;

    logic         accept;
    logic         do_hex;
    logic [7:0]   ch;
    logic [3:0]   nib;
    logic [9:0]   dec_next;
    logic         oct_ok;

    assign accept     = char_valid && char_ready;
    assign char_ready = !res_valid_reg || res_ready;
    assign res_valid  = res_valid_reg;
    assign res_beat   = res_beat_reg;

    assign ch       = char_beat.ch;
    assign nib      = hex_value(ch);
    assign dec_next = {dacc_reg[6:0], 3'b000} + {dacc_reg[8:0], 1'b0} + {6'd0, nib};
    assign oct_ok   = octet_good(dcnt_reg, alldec_reg, dacc_reg, fzero_reg);

    // Take one character.
    always_comb
    begin
        t_phase  = phase_reg;
        t_failed = failed_reg;
        t_gcnt   = gcnt_reg;
        t_gpos   = gpos_reg;
        t_gseen  = gseen_reg;
        t_hacc   = hacc_reg;
        t_dacc   = dacc_reg;
        t_dcnt   = dcnt_reg;
        t_alldec = alldec_reg;
        t_oidx   = oidx_reg;
        t_fzero  = fzero_reg;
        t_tail   = tail_reg;
        head_we  = 1'b0;
        do_hex   = 1'b0;

        if (!failed_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (ch == CH_COLON)
                        t_phase = PH_LEAD;
                    else
                        do_hex = 1'b1;
                end
                PH_LEAD:
                begin
                    if (ch != CH_COLON)
                    begin
                        t_failed = 1'b1;
                    end
                    else
                    begin
                        t_gseen = 1'b1;
                        t_gpos  = 4'd0;
                        t_tail  = '0;
                        t_phase = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    if (ch == CH_COLON)
                        t_failed = 1'b1;
                    else
                        do_hex = 1'b1;
                end
                PH_SEP:
                begin
                    if (ch == CH_COLON)
                    begin
                        if (gseen_reg)
                        begin
                            t_failed = 1'b1;
                        end
                        else
                        begin
                            // The head groups are already kept at their slots.
                            t_gseen = 1'b1;
                            t_gpos  = gcnt_reg;
                            t_tail  = '0;
                            t_phase = PH_GAP;
                        end
                    end
                    else
                    begin
                        do_hex = 1'b1;
                    end
                end
                PH_HEX:
                begin
                    do_hex = 1'b1;
                end
                PH_IP4:
                begin
                    if (ch == CH_DOT)
                    begin
                        if (!oct_ok || (oidx_reg >= 2'd3))
                        begin
                            t_failed = 1'b1;
                        end
                        else
                        begin
                            t_tail   = {tail_reg[119:0], dacc_reg[7:0]};
                            t_oidx   = oidx_reg + 2'd1;
                            t_hacc   = '0;
                            t_dacc   = '0;
                            t_dcnt   = '0;
                            t_alldec = 1'b1;
                            t_fzero  = 1'b0;
                        end
                    end
                    else if (!is_dec(ch) || (dcnt_reg >= 3'd3))
                    begin
                        t_failed = 1'b1;
                    end
                    else
                    begin
                        if (dcnt_reg == 3'd0)
                            t_fzero = (ch == CH_ZERO);
                        t_dacc = dec_next;
                        t_dcnt = dcnt_reg + 3'd1;
                    end
                end
                default:
                begin
                    t_failed = 1'b1;
                end
            endcase
        end

        // Characters of a hex group, or the first dot of a dotted quad.
        if (do_hex)
        begin
            t_phase = PH_HEX;
            if (ch == CH_COLON)
            begin
                if ((dcnt_reg == 3'd0) || (gcnt_reg >= 4'd8))
                begin
                    t_failed = 1'b1;
                end
                else
                begin
                    head_we  = !gseen_reg;
                    t_tail   = {tail_reg[111:0], hacc_reg};
                    t_gcnt   = gcnt_reg + 4'd1;
                    t_hacc   = '0;
                    t_dacc   = '0;
                    t_dcnt   = '0;
                    t_alldec = 1'b1;
                    t_fzero  = 1'b0;
                    t_phase  = PH_SEP;
                end
            end
            else if (ch == CH_DOT)
            begin
                if (!oct_ok || (gcnt_reg > 4'd6))
                begin
                    t_failed = 1'b1;
                end
                else
                begin
                    t_tail   = {tail_reg[119:0], dacc_reg[7:0]};
                    t_oidx   = 2'd1;
                    t_hacc   = '0;
                    t_dacc   = '0;
                    t_dcnt   = '0;
                    t_alldec = 1'b1;
                    t_fzero  = 1'b0;
                    t_phase  = PH_IP4;
                end
            end
            else if (!is_hex(ch) || (dcnt_reg >= 3'd4))
            begin
                t_failed = 1'b1;
            end
            else
            begin
                if (dcnt_reg == 3'd0)
                    t_fzero = (ch == CH_ZERO);
                t_hacc = {hacc_reg[11:0], nib};
                if (nib > 4'd9)
                    t_alldec = 1'b0;
                else if (dcnt_reg < 3'd3)
                    t_dacc = dec_next;
                t_dcnt = dcnt_reg + 3'd1;
            end
        end
    end

    // End-of-text checks and address assembly.
    always_comb
    begin
        f_failed = t_failed;
        f_gcnt   = t_gcnt;
        f_tail   = t_tail;

        if (!t_failed)
        begin
            case (t_phase)
                PH_HEX:
                begin
                    if ((t_dcnt == 3'd0) || (t_gcnt >= 4'd8))
                    begin
                        f_failed = 1'b1;
                    end
                    else
                    begin
                        f_tail = {t_tail[111:0], t_hacc};
                        f_gcnt = t_gcnt + 4'd1;
                    end
                end
                PH_IP4:
                begin
                    if ((t_oidx != 2'd3) || !octet_good(t_dcnt, t_alldec, t_dacc, t_fzero))
                    begin
                        f_failed = 1'b1;
                    end
                    else
                    begin
                        f_tail = {t_tail[119:0], t_dacc[7:0]};
                        f_gcnt = t_gcnt + 4'd2;
                    end
                end
                PH_GAP:
                begin
                    f_failed = 1'b0;
                end
                default:
                begin
                    f_failed = 1'b1;
                end
            endcase
        end

        // The gap must stand for at least one group; without it, all eight are given.
        if (!f_failed)
        begin
            if (t_gseen)
            begin
                if ((f_gcnt >= 4'd8) || (t_gpos > f_gcnt))
                    f_failed = 1'b1;
            end
            else if (f_gcnt != 4'd8)
            begin
                f_failed = 1'b1;
            end
        end

        // Head groups fill the slots before the gap, the tail the rest.
        addr = f_tail;
        for (int i = 0; i < GROUP_NUM; i++)
        begin
            if (t_gseen && (4'(i) < t_gpos))
                addr[127 - 16*i -: 16] = head_reg[i];
        end
    end

    // Result register.
    always_comb
    begin
        res_beat_next  = res_beat_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (accept && char_beat.last)
        begin
            res_valid_next          = 1'b1;
            res_beat_next.valid_res = !f_failed;
            res_beat_next.addr_hi   = f_failed ? 64'd0 : addr[127:64];
            res_beat_next.addr_lo   = f_failed ? 64'd0 : addr[63:0];
        end
    end

    // Next parser state: back to text start after the final character.
    always_comb
    begin
        phase_next  = phase_reg;
        failed_next = failed_reg;
        gcnt_next   = gcnt_reg;
        gpos_next   = gpos_reg;
        gseen_next  = gseen_reg;
        hacc_next   = hacc_reg;
        dacc_next   = dacc_reg;
        dcnt_next   = dcnt_reg;
        alldec_next = alldec_reg;
        oidx_next   = oidx_reg;
        fzero_next  = fzero_reg;
        tail_next   = tail_reg;
        if (accept)
        begin
            if (char_beat.last)
            begin
                phase_next  = PH_START;
                failed_next = 1'b0;
                gcnt_next   = '0;
                gpos_next   = '0;
                gseen_next  = 1'b0;
                hacc_next   = '0;
                dacc_next   = '0;
                dcnt_next   = '0;
                alldec_next = 1'b1;
                oidx_next   = '0;
                fzero_next  = 1'b0;
                tail_next   = '0;
            end
            else
            begin
                phase_next  = t_phase;
                failed_next = t_failed;
                gcnt_next   = t_gcnt;
                gpos_next   = t_gpos;
                gseen_next  = t_gseen;
                hacc_next   = t_hacc;
                dacc_next   = t_dacc;
                dcnt_next   = t_dcnt;
                alldec_next = t_alldec;
                oidx_next   = t_oidx;
                fzero_next  = t_fzero;
                tail_next   = t_tail;
            end
        end
    end

    // Control and parser registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            failed_reg    <= 1'b0;
            gcnt_reg      <= '0;
            gpos_reg      <= '0;
            gseen_reg     <= 1'b0;
            hacc_reg      <= '0;
            dacc_reg      <= '0;
            dcnt_reg      <= '0;
            alldec_reg    <= 1'b1;
            oidx_reg      <= '0;
            fzero_reg     <= 1'b0;
            tail_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            failed_reg    <= failed_next;
            gcnt_reg      <= gcnt_next;
            gpos_reg      <= gpos_next;
            gseen_reg     <= gseen_next;
            hacc_reg      <= hacc_next;
            dacc_reg      <= dacc_next;
            dcnt_reg      <= dcnt_next;
            alldec_reg    <= alldec_next;
            oidx_reg      <= oidx_next;
            fzero_reg     <= fzero_next;
            tail_reg      <= tail_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_beat_reg <= res_beat_next;
        if (accept && head_we)
            head_reg[gcnt_reg[2:0]] <= hacc_reg;
    end

`include "ipv6_text_parser_top_macros.svh"

    `IPV6TP_ASSERT(a_last_gives_result, (accept && char_beat.last) |=> res_valid,
        "final character gave no result beat")
    `IPV6TP_ASSERT(a_last_restarts, (accept && char_beat.last) |=>
        (phase_reg == PH_START && !failed_reg && gcnt_reg == 4'd0 && !gseen_reg),
        "parser did not restart after final character")
    `IPV6TP_ASSERT(a_bad_text_zero, (res_valid && !res_beat.valid_res) |->
        (res_beat.addr_hi == 64'd0 && res_beat.addr_lo == 64'd0),
        "malformed text gave a nonzero address")
    `IPV6TP_ASSERT(a_gap_within_groups, gseen_reg |-> (gpos_reg <= gcnt_reg),
        "gap position beyond group count")
    `IPV6TP_ASSERT(a_group_bound, gcnt_reg <= 4'd8, "more than eight groups stored")

endmodule

>>> verif/ipv6_text_parser_top_tb.sv
// Testbench for the IPv6 address text parser: streams address texts one character
// beat at a time and checks every result beat against a built-in parser model.
// Depends on ipv6tp_pkg and ipv6_text_parser_top.
module ipv6_text_parser_top_tb
    import ipv6tp_pkg::*;
();

// Parser model plus the store of expected result beats.
class ipv6_addr_scoreboard;
    logic [15:0] grp [8];
    logic [3:0]  gcnt;
    logic [3:0]  gap_pos;
    logic        gap_seen;
    logic [15:0] hex_acc;
    logic [9:0]  dec_acc;
    logic [2:0]  dcnt;
    logic        alldec;
    logic [1:0]  oct_idx;
    logic        fzero;
    phase_t      ph;
    logic        failed;
    res_beat_t   expected_addr_q [$];
    int          errors;

    function new();
        errors = 0;
        clear_text();
    endfunction

    // Drop the current token.
    function void clear_token();
        hex_acc = '0;
        dec_acc = '0;
        dcnt    = '0;
        alldec  = 1'b1;
        fzero   = 1'b0;
    endfunction

    // Back to the start of a new address text.
    function void clear_text();
        foreach (grp[i]) grp[i] = '0;
        gcnt     = '0;
        gap_pos  = '0;
        gap_seen = 1'b0;
        clear_token();
        oct_idx  = '0;
        ph       = PH_START;
        failed   = 1'b0;
    endfunction

    function int pending();
        return expected_addr_q.size();
    endfunction

    // Value of a hex digit, or 16 for any other character.
    function logic [4:0] nibble(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 5'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF)
            return 5'(c - CH_LA + 10);
        if (c >= CH_UA && c <= CH_UF)
            return 5'(c - CH_UA + 10);
        return 5'd16;
    endfunction

    // The finished token is a legal dotted-quad octet.
    function logic octet_fits();
        return (dcnt >= 1) && (dcnt <= 3) && alldec && (dec_acc <= 255) &&
               !(fzero && dcnt > 1);
    endfunction

    // Octet k of the dotted quad lands in the group after the explicit ones.
    function void store_octet(input int k, input logic [9:0] v);
        int gi;
        gi = (int'(gcnt) + (k >> 1)) & 7;
        if ((k & 1) == 0)
            grp[gi] = {v[7:0], 8'h00};
        else
            grp[gi] = grp[gi] | {8'h00, v[7:0]};
    endfunction

    // Character inside a hex group (or the first octet of a dotted quad).
    function void hex_step(input logic [7:0] c);
        logic [4:0] v;
        ph = PH_HEX;
        if (c == CH_COLON)
        begin
            if (dcnt == 0 || gcnt >= 8)
            begin
                failed = 1'b1;
                return;
            end
            grp[gcnt[2:0]] = hex_acc;
            gcnt++;
            clear_token();
            ph = PH_SEP;
            return;
        end
        if (c == CH_DOT)
        begin
            if (!octet_fits() || gcnt > 6)
            begin
                failed = 1'b1;
                return;
            end
            store_octet(0, dec_acc);
            oct_idx = 2'd1;
            clear_token();
            ph = PH_IP4;
            return;
        end
        v = nibble(c);
        if (v > 15 || dcnt >= 4)
        begin
            failed = 1'b1;
            return;
        end
        if (dcnt == 0)
            fzero = (c == CH_ZERO);
        hex_acc = {hex_acc[11:0], v[3:0]};
        if (v > 9)
            alldec = 1'b0;
        else if (dcnt < 3)
            dec_acc = 10'(dec_acc * 10 + v);
        dcnt++;
    endfunction

    // Character inside the dotted quad after its first dot.
    function void quad_step(input logic [7:0] c);
        if (c == CH_DOT)
        begin
            if (!octet_fits() || oct_idx >= 3)
            begin
                failed = 1'b1;
                return;
            end
            store_octet(int'(oct_idx), dec_acc);
            oct_idx++;
            clear_token();
            return;
        end
        if (c < CH_ZERO || c > CH_NINE || dcnt >= 3)
        begin
            failed = 1'b1;
            return;
        end
        if (dcnt == 0)
            fzero = (c == CH_ZERO);
        dec_acc = 10'(dec_acc * 10 + (c - CH_ZERO));
        dcnt++;
    endfunction

    function void char_step(input logic [7:0] c);
        case (ph)
            PH_START:
                if (c == CH_COLON)
                    ph = PH_LEAD;
                else
                    hex_step(c);
            PH_LEAD:
                if (c != CH_COLON)
                    failed = 1'b1;
                else
                begin
                    gap_seen = 1'b1;
                    gap_pos  = '0;
                    ph       = PH_GAP;
                end
            PH_GAP:
                if (c == CH_COLON)
                    failed = 1'b1;
                else
                    hex_step(c);
            PH_SEP:
                if (c == CH_COLON)
                begin
                    if (gap_seen)
                        failed = 1'b1;
                    else
                    begin
                        gap_seen = 1'b1;
                        gap_pos  = gcnt;
                        ph       = PH_GAP;
                    end
                end
                else
                    hex_step(c);
            PH_HEX:
                hex_step(c);
            PH_IP4:
                quad_step(c);
            default:
                failed = 1'b1;
        endcase
    endfunction

    // Close the last token and check the group count against the gap.
    function void close_text();
        case (ph)
            PH_HEX:
                if (dcnt == 0 || gcnt >= 8)
                    failed = 1'b1;
                else
                begin
                    grp[gcnt[2:0]] = hex_acc;
                    gcnt++;
                end
            PH_IP4:
                if (oct_idx != 3 || !octet_fits())
                    failed = 1'b1;
                else
                begin
                    store_octet(3, dec_acc);
                    gcnt = gcnt + 4'd2;
                end
            PH_GAP:
                ;
            default:
                failed = 1'b1;
        endcase
        if (failed)
            return;
        if (gap_seen)
        begin
            if (gcnt >= 8 || gap_pos > gcnt)
                failed = 1'b1;
        end
        else if (gcnt != 8)
            failed = 1'b1;
    endfunction

    // Accepted character beat; the final one yields an expected result beat.
    function void note_char(input char_beat_t b);
        logic [15:0] g [8];
        res_beat_t   r;
        int          tail;
        int          gp;
        if (!failed)
            char_step(b.ch);
        if (!b.last)
            return;
        if (!failed)
            close_text();
        foreach (g[i]) g[i] = '0;
        r = '0;
        if (!failed)
        begin
            gp = int'(gap_pos);
            if (gap_seen)
            begin
                tail = int'(gcnt) - gp;
                for (int i = 0; i < gp; i++)
                    g[i & 7] = grp[i & 7];
                for (int i = 0; i < tail; i++)
                    g[(8 - tail + i) & 7] = grp[(gp + i) & 7];
            end
            else
                foreach (g[i]) g[i] = grp[i];
            r.valid_res = 1'b1;
            r.addr_hi   = {g[0], g[1], g[2], g[3]};
            r.addr_lo   = {g[4], g[5], g[6], g[7]};
        end
        expected_addr_q.push_back(r);
        clear_text();
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(input res_beat_t r);
        res_beat_t e;
        if (expected_addr_q.size() == 0)
        begin
            $display("%0t: result beat with none expected, actual %h", $time, r);
            errors++;
            return;
        end
        e = expected_addr_q.pop_front();
        if (r.valid_res !== e.valid_res)
        begin
            $display("%0t: valid_res expected %0b actual %0b", $time, e.valid_res,
                     r.valid_res);
            errors++;
        end
        if (r.addr_hi !== e.addr_hi)
        begin
            $display("%0t: addr_hi expected %h actual %h", $time, e.addr_hi, r.addr_hi);
            errors++;
        end
        if (r.addr_lo !== e.addr_lo)
        begin
            $display("%0t: addr_lo expected %h actual %h", $time, e.addr_lo, r.addr_lo);
            errors++;
        end
    endfunction
endclass

    localparam int CYCLE_LIMIT = 400000;
    localparam int CHARS_PER_PASS = 390;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       char_valid = 1'b0;
    logic       char_ready;
    char_beat_t char_beat = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    res_beat_t  res_beat;

    ipv6_addr_scoreboard sb;
    logic [7:0] text_q [$];
    int         send_idle = 0;
    int         recv_idle = 0;
    int         cycle_count = 0;

    ipv6_text_parser_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_beat  (char_beat),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_beat   (res_beat)
    );

    always #6 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check each accepted beat, then stall at random.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_beat);
        res_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Offer one character beat and hold it until it is accepted.
    task drive_char(input char_beat_t b);
        while ($urandom_range(0, 99) < send_idle)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_beat  <= b;
        do
            @(posedge clk);
        while (!(char_valid && char_ready));
        sb.note_char(b);
    endtask

    // Stream the text in text_q, flagging its final character.
    task send_text();
        char_beat_t b;
        for (int i = 0; i < text_q.size(); i++)
        begin
            b.ch   = text_q[i];
            b.last = (i == text_q.size() - 1);
            drive_char(b);
        end
    endtask

    task push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function logic [7:0] hex_digit_char(input int v);
        if (v < 10)
            return 8'(CH_ZERO + v);
        return 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - 10);
    endfunction

    // One group of 1 to 4 digits; some groups are all decimal digits.
    task push_group();
        int  d;
        bit  dec_only;
        d = $urandom_range(1, 4);
        dec_only = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < d; i++)
            if (dec_only)
                text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            else
                text_q.push_back(hex_digit_char($urandom_range(0, 15)));
    endtask

    task push_octet(input int v);
        if (v >= 100)
            text_q.push_back(8'(CH_ZERO + v / 100));
        if (v >= 10)
            text_q.push_back(8'(CH_ZERO + (v / 10) % 10));
        text_q.push_back(8'(CH_ZERO + v % 10));
    endtask

    // Dotted quad, leaning on the octet extremes.
    task push_quad();
        for (int k = 0; k < 4; k++)
        begin
            if (k > 0)
                text_q.push_back(CH_DOT);
            case ($urandom_range(0, 3))
                0: push_octet(0);
                1: push_octet(255);
                default: push_octet($urandom_range(0, 255));
            endcase
        end
    endtask

    // Alter a well-formed text in one place, which mostly breaks it.
    task mutate_text();
        int pos;
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 6))
            0: text_q[pos] = 8'($urandom_range(0, 255));
            1: text_q.insert(pos, CH_COLON);
            2: if (text_q.size() > 1) text_q.delete(pos);
            3: text_q.insert(pos, CH_DOT);
            4: while (text_q.size() > pos + 1) void'(text_q.pop_back());
            5: text_q.insert(pos, CH_ZERO);
            default: push_str(":0");
        endcase
    endtask

    // Random text: mostly well-formed addresses, some broken, some noise.
    task build_text();
        int kind;
        int n;
        int lft;
        int rgt;
        bit with_quad;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 85)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // Full form, optionally ending in a dotted quad.
                with_quad = ($urandom_range(0, 2) == 0);
                n = with_quad ? 6 : 8;
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        text_q.push_back(CH_COLON);
                    push_group();
                end
                if (with_quad)
                begin
                    text_q.push_back(CH_COLON);
                    push_quad();
                end
            end
            else
            begin
                // Compressed form with the gap anywhere.
                with_quad = ($urandom_range(0, 3) == 0);
                n   = $urandom_range(with_quad ? 2 : 0, 7);
                rgt = $urandom_range(with_quad ? 2 : 0, n);
                lft = n - rgt;
                if (with_quad)
                    rgt -= 2;
                for (int i = 0; i < lft; i++)
                begin
                    if (i > 0)
                        text_q.push_back(CH_COLON);
                    push_group();
                end
                push_str("::");
                for (int i = 0; i < rgt; i++)
                begin
                    if (i > 0)
                        text_q.push_back(CH_COLON);
                    push_group();
                end
                if (with_quad)
                begin
                    if (rgt > 0)
                        text_q.push_back(CH_COLON);
                    push_quad();
                end
            end
            if (kind >= 65)
                mutate_text();
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                case ($urandom_range(0, 5))
                    0: text_q.push_back(CH_COLON);
                    1: text_q.push_back(CH_DOT);
                    2: text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    3: text_q.push_back(hex_digit_char($urandom_range(10, 16)));
                    default: text_q.push_back(8'($urandom_range(0, 255)));
                endcase
        end
    endtask

    initial
    begin
        string directed_txt [];
        int    sent;
        sb = new();
        directed_txt = '{"::", ":", "1::", "::1", ":1", "1:", ":::", "1::2::3",
                         "FFFF:ffff:0:0:0:0:Abcd:9999", "1:2:3:4:5:6:7:8:9",
                         "1:2:3:4:5:6:7::", "1:2:3:4:5:6:7::8", "1:2:3:4:5:6:7",
                         "12345::", "g::", "::255.255.255.255", "1:2:3:4:5:6:0.0.0.0",
                         "1:2:3:4:5:6:7:1.2.3.4", "::256.0.0.1", "::01.2.3.4",
                         "::1.2.3", "::1.2.3.4.5", "::1.2.a.4", "1.2.3.4::"};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: extremes and each malformed case.
        send_idle = 34;
        recv_idle = 87;
        foreach (directed_txt[i])
        begin
            text_q.delete();
            push_str(directed_txt[i]);
            send_text();
        end

        // Random texts in three idling passes.
        for (int pass = 0; pass < 3; pass++)
        begin
            send_idle = (pass == 0) ? 34 : (pass == 1) ? 87 : 0;
            recv_idle = (pass == 0) ? 87 : (pass == 1) ? 34 : 0;
            sent = 0;
            while (sent < CHARS_PER_PASS)
            begin
                build_text();
                sent += text_q.size();
                send_text();
            end
        end
        char_valid <= 1'b0;

        // Drain outstanding result beats.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/ipv6tp_pkg.sv
sv/ipv6_text_parser_top.sv
verif/ipv6_text_parser_top_tb.sv
